// ----- rtl/nsc_pkg.sv -----
// nsc_pkg: shared widths, register indexes and helper functions for the
// nearest segment crossing block; no dependencies
`default_nettype none

package nsc_pkg;

  localparam int CFG_IDX_W = 2;
  localparam int CW        = 32;  // coordinate width
  localparam int QUO_W     = 65;  // divider quotient and dividend bit stream
  localparam int DEN_W     = 67;  // divider divisor
  localparam int REM_W     = 68;  // divider remainder
  localparam int STEP_W    = 7;   // divider step count

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_QUERY_START_X = 2'd0,
    REG_QUERY_START_Y = 2'd1,
    REG_QUERY_END_X   = 2'd2,
    REG_QUERY_END_Y   = 2'd3
  } cfg_reg_t;

  function automatic logic [32:0] abs33(input logic signed [32:0] v);
    abs33 = v[32] ? 33'(-v) : 33'(v);
  endfunction

  function automatic logic [65:0] abs66(input logic signed [65:0] v);
    abs66 = v[65] ? 66'(-v) : 66'(v);
  endfunction

  // clamp to the signed 32-bit range
  function automatic logic signed [CW-1:0] sat32(input logic signed [100:0] v);
    logic signed [100:0] vmax;
    logic signed [100:0] vmin;
    vmax = 101'sd2147483647;
    vmin = -101'sd2147483648;
    if (v > vmax) begin
      sat32 = 32'sh7fffffff;
    end else if (v < vmin) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[CW-1:0];
    end
  endfunction

endpackage

`default_nettype wire

// ----- rtl/nsc_if.sv -----
// nsc_if: valid/ready channel interfaces for segment input and result output
// depends on nothing
`default_nettype none

interface nsc_seg_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] seg_start_x;
  logic signed [31:0] seg_start_y;
  logic signed [31:0] seg_end_x;
  logic signed [31:0] seg_end_y;
  logic               last_segment;

  modport source (output valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
                  last_segment, input ready);
  modport sink (input valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
                last_segment, output ready);
endinterface

interface nsc_res_if;
  logic               valid;
  logic               ready;
  logic               found;
  logic signed [31:0] cross_x;
  logic signed [31:0] cross_y;
  logic [15:0]        crossing_count;

  modport source (output valid, found, cross_x, cross_y, crossing_count, input ready);
  modport sink (input valid, found, cross_x, cross_y, crossing_count, output ready);
endinterface

`default_nettype wire

// ----- rtl/nsc_div.sv -----
// nsc_div: restoring serial divider, one quotient bit per cycle
// depends on nsc_pkg
`default_nettype none

module nsc_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [nsc_pkg::REM_W-1:0]   rem_init,
  input  logic [nsc_pkg::QUO_W-1:0]   bits_in,
  input  logic [nsc_pkg::DEN_W-1:0]   den,
  input  logic [nsc_pkg::STEP_W-1:0]  steps,
  output logic                        done,
  output logic [nsc_pkg::QUO_W-1:0]   quo
);
  import nsc_pkg::*;

  logic              busy;
  logic [STEP_W-1:0] cnt;
  logic [REM_W-1:0]  rem;
  logic [QUO_W-1:0]  sh;
  logic [DEN_W-1:0]  den_r;
  logic [REM_W-1:0]  r2;
  logic              ge;

  assign r2 = {rem[REM_W-2:0], sh[QUO_W-1]};
  assign ge = r2 >= REM_W'(den_r);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= steps;
        rem   <= rem_init;
        sh    <= bits_in;
        den_r <= den;
        quo   <= '0;
      end else if (busy) begin
        rem <= ge ? r2 - REM_W'(den_r) : r2;
        quo <= {quo[QUO_W-2:0], ge};
        sh  <= {sh[QUO_W-2:0], 1'b0};
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/nearest_segment_crossing.sv -----
// nearest_segment_crossing: top level, sequencer with a shared 34x34 multiplier
// depends on nsc_pkg, nsc_if (nsc_seg_if, nsc_res_if) and nsc_div
`default_nettype none

// Finds the crossing of a stream of segments with a query segment held in
// four registers (Q16.16), keeping the one nearest the query start. One
// segment is taken at a time: the crossing test takes four cross products
// (eight products through the shared multiplier). A segment that crosses
// also needs one slope (when either segment is vertical) or two slopes and
// an intersection quotient on the serial divider, one bit a cycle, plus a few
// multiplier passes. seg.ready is high only while the block is idle. The
// result for a query is given on the last segment and sits in an output
// register, so the next segment can be taken while it waits.

module nearest_segment_crossing (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [nsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [31:0]                    cfg_wdata,
  nsc_seg_if.sink                        seg,
  nsc_res_if.source                      res
);
  import nsc_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_CROSS  = 11'b00000000010,
    S_SLOPE1 = 11'b00000000100,
    S_SLOPE2 = 11'b00000001000,
    S_NUM1   = 11'b00000010000,
    S_NUM2   = 11'b00000100000,
    S_XDIV   = 11'b00001000000,
    S_YSEL   = 11'b00010000000,
    S_ALONG  = 11'b00100000000,
    S_DIST   = 11'b01000000000,
    S_DONE   = 11'b10000000000
  } state_t;

  state_t state;
  logic [3:0] step;

  // query segment registers
  logic signed [31:0] qsx, qsy, qex, qey;
  // captured segment
  logic signed [31:0] bsx, bsy, bex, bey;
  logic               last;

  // datapath registers
  logic [3:0]          left;
  logic signed [67:0]  prod;
  logic signed [67:0]  acc;
  logic [98:0]         bigacc;
  logic signed [65:0]  ma, mb;
  logic signed [100:0] num;
  logic signed [31:0]  xr, yr;

  // per-query state
  logic [63:0]        best_dsq;
  logic signed [31:0] best_x, best_y;
  logic               have_cross;
  logic [15:0]        hit_count;

  // output register
  logic               out_valid;
  logic               out_found;
  logic signed [31:0] out_x, out_y;
  logic [15:0]        out_count;

  // segment deltas
  logic signed [32:0] dxa, dya, dxb, dyb;
  logic               case_a, case_b, case_c;

  assign dxa = 33'(qex) - 33'(qsx);
  assign dya = 33'(qey) - 33'(qsy);
  assign dxb = 33'(bex) - 33'(bsx);
  assign dyb = 33'(bey) - 33'(bsy);
  assign case_a = (dxa == 33'sd0);                 // vertical query
  assign case_b = !case_a && (dxb == 33'sd0);      // vertical segment
  assign case_c = !case_a && !case_b;

  // cross product operands: test = step[2:1], term = step[0]
  logic signed [31:0] px, py, lax, lay, lbx, lby;
  logic signed [32:0] cr_a, cr_b;
  logic signed [68:0] cp;
  logic               cp_pos;
  logic [1:0]         lidx;

  always_comb begin
    case (step[2:1])
      2'd0: begin
        px = qsx;
        py = qsy;
      end
      2'd1: begin
        px = qex;
        py = qey;
      end
      2'd2: begin
        px = bsx;
        py = bsy;
      end
      default: begin
        px = bex;
        py = bey;
      end
    endcase
    if (step[2]) begin
      lax = qsx;
      lay = qsy;
      lbx = qex;
      lby = qey;
    end else begin
      lax = bsx;
      lay = bsy;
      lbx = bex;
      lby = bey;
    end
    if (step[0]) begin
      cr_a = 33'(py) - 33'(lay);
      cr_b = 33'(px) - 33'(lbx);
    end else begin
      cr_a = 33'(px) - 33'(lax);
      cr_b = 33'(py) - 33'(lby);
    end
  end

  // left-of test, strictly positive only
  assign cp     = 69'(acc) - 69'(prod);
  assign cp_pos = !cp[68] && (cp != 69'sd0);
  assign lidx   = 2'(step[3:1] - 3'd1);

  // wide products as two 33-bit limbs of a magnitude
  logic [65:0]        big_a;
  logic [32:0]        big_b;
  logic               big_neg;
  logic [32:0]        limb;
  logic [98:0]        big_res;
  logic signed [99:0] big_sres;
  logic signed [31:0] x0, y0;
  logic signed [32:0] along_d;

  assign x0      = case_a ? bsx : qsx;
  assign y0      = case_a ? bsy : qsy;
  assign along_d = 33'(xr) - 33'(x0);

  always_comb begin
    case (state)
      S_NUM1: begin
        big_a   = abs66(ma);
        big_b   = abs33(33'(qsx));
        big_neg = ma[65] ^ qsx[31];
      end
      S_NUM2: begin
        big_a   = abs66(mb);
        big_b   = abs33(33'(bsx));
        big_neg = mb[65] ^ bsx[31];
      end
      default: begin
        big_a   = abs66(ma);
        big_b   = abs33(along_d);
        big_neg = ma[65] ^ along_d[32];
      end
    endcase
  end

  assign limb     = step[0] ? big_a[65:33] : big_a[32:0];
  assign big_res  = bigacc + (99'(prod[65:0]) << 33);
  assign big_sres = big_neg ? -$signed({1'b0, big_res}) : $signed({1'b0, big_res});

  // squared distance operands
  logic signed [32:0] ddx, ddy, dd;
  logic [68:0]        dsum;
  logic [63:0]        dsq;

  assign ddx  = 33'(xr) - 33'(qsx);
  assign ddy  = 33'(yr) - 33'(qsy);
  assign dd   = step[0] ? ddy : ddx;
  assign dsum = 69'($unsigned(acc)) + 69'($unsigned(prod));
  assign dsq  = (dsum[68:64] != 5'd0) ? 64'hffff_ffff_ffff_ffff : dsum[63:0];

  // shared multiplier
  logic signed [33:0] mul_a, mul_b;

  always_comb begin
    mul_a = 34'(cr_a);
    mul_b = 34'(cr_b);
    if (state == S_NUM1 || state == S_NUM2 || state == S_ALONG) begin
      mul_a = $signed({1'b0, limb});
      mul_b = $signed({1'b0, big_b});
    end else if (state == S_DIST) begin
      mul_a = 34'(dd);
      mul_b = 34'(dd);
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // slope and intersection division setup
  logic signed [32:0] sl_dy, sl_dx;
  logic [32:0]        sl_dy_mag, sl_dx_mag;
  logic               sl_neg;
  logic signed [65:0] sl_val;
  logic signed [66:0] den;
  logic [66:0]        den_mag;
  logic [99:0]        num_mag;
  logic               x_neg;
  logic               x_big;
  logic signed [34:0] xq;

  assign sl_dy     = (state == S_SLOPE2 || case_a) ? dyb : dya;
  assign sl_dx     = (state == S_SLOPE2 || case_a) ? dxb : dxa;
  assign sl_dy_mag = abs33(sl_dy);
  assign sl_dx_mag = abs33(sl_dx);
  assign sl_neg    = sl_dy[32] ^ sl_dx[32];

  assign den     = 67'(ma) - 67'(mb);
  assign den_mag = den[66] ? 67'(-den) : 67'(den);
  assign num_mag = num[100] ? 100'(-num) : 100'(num);
  assign x_neg   = num[100] ^ den[66];
  assign x_big   = {1'b0, num_mag} >= {den_mag, 34'd0};

  logic                div_start;
  logic [REM_W-1:0]    div_rem_init;
  logic [QUO_W-1:0]    div_bits;
  logic [DEN_W-1:0]    div_den;
  logic [STEP_W-1:0]   div_steps;
  logic                div_done;
  logic [QUO_W-1:0]    div_quo;

  always_comb begin
    div_start = 1'b0;
    if (step == 4'd0) begin
      if (state == S_SLOPE1 || state == S_SLOPE2) begin
        div_start = (sl_dx != 33'sd0);
      end else if (state == S_XDIV) begin
        div_start = (den != 67'sd0) && !x_big;
      end
    end
    if (state == S_XDIV) begin
      div_rem_init = REM_W'(num_mag >> 34);
      div_bits     = {num_mag[33:0], 31'd0};
      div_den      = den_mag;
      div_steps    = 7'd34;
    end else begin
      div_rem_init = '0;
      div_bits     = {sl_dy_mag, 32'd0};
      div_den      = DEN_W'(sl_dx_mag);
      div_steps    = 7'd65;
    end
  end

  assign sl_val = sl_neg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
  assign xq     = x_neg ? -$signed({1'b0, div_quo[33:0]}) : $signed({1'b0, div_quo[33:0]});

  nsc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .rem_init (div_rem_init),
    .bits_in  (div_bits),
    .den      (div_den),
    .steps    (div_steps),
    .done     (div_done),
    .quo      (div_quo)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      qsx <= '0;
      qsy <= '0;
      qex <= '0;
      qey <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_QUERY_START_X: qsx <= cfg_wdata;
        REG_QUERY_START_Y: qsy <= cfg_wdata;
        REG_QUERY_END_X:   qex <= cfg_wdata;
        REG_QUERY_END_Y:   qey <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign seg.ready = (state == S_IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      step       <= '0;
      best_dsq   <= '1;
      best_x     <= '0;
      best_y     <= '0;
      have_cross <= 1'b0;
      hit_count  <= '0;
      out_valid  <= 1'b0;
    end else begin
      // a result issued on the last segment takes over the output register
      if (res.ready && !(state == S_DONE && last)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (seg.valid) begin
            bsx   <= seg.seg_start_x;
            bsy   <= seg.seg_start_y;
            bex   <= seg.seg_end_x;
            bey   <= seg.seg_end_y;
            last  <= seg.last_segment;
            step  <= '0;
            state <= S_CROSS;
          end
        end
        S_CROSS: begin
          if (step != 4'd0) begin
            if (step[0]) begin
              acc <= prod;
            end else begin
              left[lidx] <= cp_pos;
            end
          end
          if (step == 4'd8) begin
            step <= '0;
            if ((left[0] != left[1]) && (left[2] != cp_pos)) begin
              state <= S_SLOPE1;
            end else begin
              state <= S_DONE;
            end
          end else begin
            step <= step + 4'd1;
          end
        end
        S_SLOPE1: begin
          if (step == 4'd0) begin
            if (sl_dx == 33'sd0) begin
              ma    <= '0;
              state <= S_ALONG;
              xr    <= qsx;
            end else begin
              step <= 4'd1;
            end
          end else if (div_done) begin
            ma   <= sl_val;
            step <= '0;
            if (case_c) begin
              state <= S_SLOPE2;
            end else begin
              state <= S_ALONG;
              xr    <= case_a ? qsx : bsx;
            end
          end
        end
        S_SLOPE2: begin
          if (step == 4'd0) begin
            step <= 4'd1;
          end else if (div_done) begin
            mb    <= sl_val;
            step  <= '0;
            state <= S_NUM1;
          end
        end
        S_NUM1: begin
          if (step == 4'd1) begin
            bigacc <= 99'(prod[65:0]);
          end
          if (step == 4'd2) begin
            num   <= 101'(big_sres) + (101'(33'(bsy) - 33'(qsy)) <<< 32);
            step  <= '0;
            state <= S_NUM2;
          end else begin
            step <= step + 4'd1;
          end
        end
        S_NUM2: begin
          if (step == 4'd1) begin
            bigacc <= 99'(prod[65:0]);
          end
          if (step == 4'd2) begin
            num   <= num - 101'(big_sres);
            step  <= '0;
            state <= S_XDIV;
          end else begin
            step <= step + 4'd1;
          end
        end
        S_XDIV: begin
          if (step == 4'd0) begin
            if (den == 67'sd0) begin
              // parallel after truncation: clamp by the numerator's sign
              if (num == 101'sd0) begin
                xr <= '0;
              end else begin
                xr <= num[100] ? 32'sh80000000 : 32'sh7fffffff;
              end
              state <= S_YSEL;
            end else if (x_big) begin
              xr    <= x_neg ? 32'sh80000000 : 32'sh7fffffff;
              state <= S_YSEL;
            end else begin
              step <= 4'd1;
            end
          end else if (div_done) begin
            xr    <= sat32(101'(xq));
            step  <= '0;
            state <= S_YSEL;
          end
        end
        S_YSEL: begin
          step <= '0;
          if (dya == 33'sd0) begin
            yr    <= qsy;
            state <= S_DIST;
          end else if (dyb == 33'sd0) begin
            yr    <= bsy;
            state <= S_DIST;
          end else begin
            state <= S_ALONG;
          end
        end
        S_ALONG: begin
          if (step == 4'd1) begin
            bigacc <= 99'(prod[65:0]);
          end
          if (step == 4'd2) begin
            // divide by 2^32 toward zero on the magnitude
            if (big_neg) begin
              yr <= sat32(101'(-$signed({1'b0, big_res[98:32]})) + 101'(y0));
            end else begin
              yr <= sat32(101'($signed({1'b0, big_res[98:32]})) + 101'(y0));
            end
            step  <= '0;
            state <= S_DIST;
          end else begin
            step <= step + 4'd1;
          end
        end
        S_DIST: begin
          if (step == 4'd1) begin
            acc <= prod;
          end
          if (step == 4'd2) begin
            if (!have_cross || dsq < best_dsq) begin
              best_dsq   <= dsq;
              best_x     <= xr;
              best_y     <= yr;
              have_cross <= 1'b1;
            end
            if (hit_count != 16'hffff) begin
              hit_count <= hit_count + 16'd1;
            end
            step  <= '0;
            state <= S_DONE;
          end else begin
            step <= step + 4'd1;
          end
        end
        S_DONE: begin
          if (!last) begin
            state <= S_IDLE;
          end else if (!out_valid || res.ready) begin
            out_valid  <= 1'b1;
            out_found  <= have_cross;
            out_x      <= have_cross ? best_x : 32'sd0;
            out_y      <= have_cross ? best_y : 32'sd0;
            out_count  <= hit_count;
            // clear for the next query
            best_dsq   <= '1;
            best_x     <= '0;
            best_y     <= '0;
            have_cross <= 1'b0;
            hit_count  <= '0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
          step  <= '0;
        end
      endcase
    end
  end

  assign res.valid          = out_valid;
  assign res.found          = out_found;
  assign res.cross_x        = out_x;
  assign res.cross_y        = out_y;
  assign res.crossing_count = out_count;

endmodule

`default_nettype wire

// ----- rtl/nsc_checker.sv -----
// nsc_checker: port-level assertions for nearest_segment_crossing
// depends on nothing; bound to the top level at the end of this file
`default_nettype none

module nsc_checker (
  input logic        clk,
  input logic        rst,
  input logic        seg_valid,
  input logic        seg_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic        res_found,
  input logic [31:0] res_cross_x,
  input logic [31:0] res_cross_y,
  input logic [15:0] res_count
);

  // a stalled result stays offered
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");

  // one segment at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    seg_valid && seg_ready |=> !seg_ready)
    else $error("segment taken while busy");

  // no crossing gives a zero point
  a_zero_point: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_found |-> res_cross_x == 32'd0 && res_cross_y == 32'd0)
    else $error("point not zero without crossing");

  // found flag agrees with the crossing count
  a_found_count: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_found == (res_count != 16'd0))
    else $error("found flag and count disagree");

endmodule

bind nearest_segment_crossing nsc_checker u_nsc_checker (
  .clk         (clk),
  .rst         (rst),
  .seg_valid   (seg.valid),
  .seg_ready   (seg.ready),
  .res_valid   (res.valid),
  .res_ready   (res.ready),
  .res_found   (res.found),
  .res_cross_x (res.cross_x),
  .res_cross_y (res.cross_y),
  .res_count   (res.crossing_count)
);

`default_nettype wire
